// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rse_pkg.sv =====
// Shared constants, types and GF(2^8) helpers of the RS parity encoder.
package rse_pkg;

    localparam int MAX_PARITY = 64;
    localparam int SYM_W      = 8;
    localparam int CFG_W      = 7;
    localparam int FED_W      = 8;
    localparam int CODE_LEN   = 255;
    localparam int PA_W       = $clog2(MAX_PARITY);
    localparam int PL_W       = $clog2(MAX_PARITY + 1);

    // 0x11D without the x^8 term
    localparam logic [SYM_W-1:0] GF_POLY_LOW = 8'h1D;
    localparam logic [CFG_W-1:0] PLEN_RESET  = 7'd16;

    typedef enum logic [3:0] {
        ST_GINIT,
        ST_GSTEP,
        ST_GDRAIN,
        ST_IDLE,
        ST_FB,
        ST_SHIFT,
        ST_DRAIN,
        ST_ERD,
        ST_EOUT,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [SYM_W-1:0] parity_symbol;
        logic             end_of_parity;
        logic             too_long;
    } t_res;

    typedef struct packed {
        logic in_ready;
        logic cfg_ready;
    } t_stat;

    // multiply by alpha
    function automatic logic [SYM_W-1:0] gf_xtime(input logic [SYM_W-1:0] a);
        gf_xtime = {a[SYM_W-2:0], 1'b0} ^ (a[SYM_W-1] ? GF_POLY_LOW : '0);
    endfunction

endpackage

// ===== rtl/rse_gf_mul.sv =====
// Shared GF(2^8) multiplier, shift-and-add over the field polynomial.
module rse_gf_mul import rse_pkg::*; (
    input  logic [SYM_W-1:0] i_a,
    input  logic [SYM_W-1:0] i_b,
    output logic [SYM_W-1:0] o_prod
);

    always_comb begin
        logic [SYM_W-1:0] acc;
        logic [SYM_W-1:0] x;
        acc = '0;
        x   = i_a;
        for (int n = 0; n < SYM_W; n++) begin
            if (i_b[n]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        o_prod = acc;
    end

endmodule

// ===== rtl/rse_core.sv =====
// Sequencer, coefficient and remainder memories around one GF multiplier.
module rse_core import rse_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr,
    input  logic [PL_W-1:0] i_plen_eff,
    input  logic            i_item_valid,
    input  t_item           i_item,
    output t_stat           o_stat,
    output logic            o_res_valid,
    output t_res            o_res,
    input  logic            i_res_ready
);

    t_state r_state, n_state;

    logic [SYM_W-1:0] par_mem [MAX_PARITY];
    logic [SYM_W-1:0] gen_mem [MAX_PARITY];
    logic [MAX_PARITY-1:0] r_vld;

    logic [PL_W-1:0]  r_i, r_k, r_waddr;
    logic [PA_W-1:0]  r_j, r_e;
    logic [SYM_W-1:0] r_root, r_mop, r_sym;
    logic [FED_W-1:0] r_fed;
    logic             r_ovf, r_tail, r_pend, r_wgen;

    logic [SYM_W-1:0] r_prd, r_ga, r_gb;
    logic             r_pvld, r_ga_z, r_gb_z;

    logic [PL_W-1:0]  plm1, km1;
    logic [PA_W-1:0]  pm1, jm1;
    logic [FED_W-1:0] kk;
    logic             new_ovf, item_go, res_go, clear_msg;

    logic [PA_W-1:0]  p_raddr, ga_addr, gb_addr;
    logic             p_rzero, ga_zero, gb_zero;
    logic [SYM_W-1:0] pdat, gadat, gbdat, prod, wdata;

    assign plm1    = i_plen_eff - PL_W'(1);
    assign pm1     = plm1[PA_W-1:0];
    assign km1     = r_k - PL_W'(1);
    assign jm1     = r_j - PA_W'(1);
    assign kk      = FED_W'(CODE_LEN) - FED_W'(i_plen_eff);
    assign new_ovf = r_ovf || (r_fed >= kk);
    assign item_go = i_item_valid && (r_state == ST_IDLE);
    assign res_go  = o_res_valid && i_res_ready;

    // read address selection
    always_comb begin
        p_raddr = '0;
        p_rzero = 1'b1;
        ga_addr = '0;
        ga_zero = 1'b1;
        gb_addr = '0;
        gb_zero = 1'b1;
        unique case (r_state)
            ST_GSTEP: begin
                ga_addr = r_k[PA_W-1:0];
                ga_zero = (r_k == r_i);
                gb_addr = km1[PA_W-1:0];
                gb_zero = (r_k == '0);
            end
            ST_FB: begin
                p_raddr = pm1;
                p_rzero = 1'b0;
            end
            ST_SHIFT: begin
                p_raddr = jm1;
                p_rzero = (r_j == '0);
                ga_addr = r_j;
                ga_zero = 1'b0;
            end
            ST_ERD, ST_EOUT: begin
                p_raddr = r_e;
                p_rzero = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prd  <= par_mem[p_raddr];
        r_pvld <= r_vld[p_raddr] && !p_rzero;
        r_ga   <= gen_mem[ga_addr];
        r_ga_z <= ga_zero;
        r_gb   <= gen_mem[gb_addr];
        r_gb_z <= gb_zero;
    end

    assign pdat  = r_pvld ? r_prd : '0;
    assign gadat = r_ga_z ? '0 : r_ga;
    assign gbdat = r_gb_z ? '0 : r_gb;

    rse_gf_mul u_mul (
        .i_a    (gadat),
        .i_b    (r_mop),
        .o_prod (prod)
    );

    assign wdata = (r_wgen ? gbdat : pdat) ^ prod;

    // write-back of the step issued last cycle
    always_ff @(posedge i_clk) begin
        if (r_pend && r_wgen && (r_waddr < PL_W'(MAX_PARITY))) begin
            gen_mem[r_waddr[PA_W-1:0]] <= wdata;
        end else if (r_state == ST_GINIT) begin
            gen_mem[0] <= SYM_W'(1);
        end
        if (r_pend && !r_wgen) begin
            par_mem[r_waddr[PA_W-1:0]] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (clear_msg) begin
            r_vld <= '0;
        end else if (r_pend && !r_wgen) begin
            r_vld[r_waddr[PA_W-1:0]] <= 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (i_cfg_wr) begin
            n_state = ST_GINIT;
        end else begin
            unique case (r_state)
                ST_GINIT:  n_state = ST_GSTEP;
                ST_GSTEP: begin
                    if ((r_k == '0) && (r_i == i_plen_eff)) n_state = ST_GDRAIN;
                end
                ST_GDRAIN: n_state = ST_IDLE;
                ST_IDLE: begin
                    if (item_go) begin
                        if (!new_ovf)         n_state = ST_FB;
                        else if (i_item.last) n_state = ST_ERR;
                    end
                end
                ST_FB:     n_state = ST_SHIFT;
                ST_SHIFT: begin
                    if (r_j == '0) n_state = ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (!r_tail)         n_state = ST_IDLE;
                    else if (r_fed < kk) n_state = ST_FB;
                    else                 n_state = ST_ERD;
                end
                ST_ERD:    n_state = ST_EOUT;
                ST_EOUT: begin
                    if (res_go) n_state = (r_e == pm1) ? ST_IDLE : ST_ERD;
                end
                ST_ERR: begin
                    if (res_go) n_state = ST_IDLE;
                end
                default:   n_state = ST_GINIT;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_stat.in_ready  = (r_state == ST_IDLE);
        o_stat.cfg_ready = (r_state == ST_IDLE) || (r_state == ST_GINIT) ||
                           (r_state == ST_GSTEP) || (r_state == ST_GDRAIN);
        o_res_valid = 1'b0;
        o_res       = '0;
        clear_msg   = i_cfg_wr;
        unique case (r_state)
            ST_EOUT: begin
                o_res_valid         = 1'b1;
                o_res.parity_symbol = pdat;
                o_res.end_of_parity = (r_e == pm1);
                clear_msg           = i_cfg_wr || (i_res_ready && (r_e == pm1));
            end
            ST_ERR: begin
                o_res_valid         = 1'b1;
                o_res.end_of_parity = 1'b1;
                o_res.too_long      = 1'b1;
                clear_msg           = i_cfg_wr || i_res_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_GINIT;
            r_pend  <= 1'b0;
            r_wgen  <= 1'b0;
            r_waddr <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_e     <= '0;
            r_root  <= '0;
            r_mop   <= '0;
            r_sym   <= '0;
            r_tail  <= 1'b0;
            r_fed   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= 1'b0;
            unique case (r_state)
                ST_GINIT: begin
                    r_i    <= PL_W'(1);
                    r_k    <= PL_W'(1);
                    r_root <= gf_xtime(SYM_W'(1));
                end
                ST_GSTEP: begin
                    r_pend  <= 1'b1;
                    r_wgen  <= 1'b1;
                    r_waddr <= r_k;
                    r_mop   <= r_root;
                    if (r_k == '0) begin
                        r_i    <= r_i + PL_W'(1);
                        r_k    <= r_i + PL_W'(1);
                        r_root <= gf_xtime(r_root);
                    end else begin
                        r_k <= km1;
                    end
                end
                ST_IDLE: begin
                    if (item_go) begin
                        if (new_ovf) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_sym  <= i_item.symbol;
                            r_tail <= i_item.last;
                            r_fed  <= r_fed + FED_W'(1);
                        end
                    end
                end
                ST_FB: begin
                    r_j <= pm1;
                end
                ST_SHIFT: begin
                    r_pend  <= 1'b1;
                    r_wgen  <= 1'b0;
                    r_waddr <= PL_W'(r_j);
                    if (r_j == pm1) r_mop <= r_sym ^ pdat;   // feedback term
                    r_j <= jm1;
                end
                ST_DRAIN: begin
                    r_e <= '0;
                    if (r_tail && (r_fed < kk)) begin
                        r_sym <= '0;
                        r_fed <= r_fed + FED_W'(1);
                    end
                end
                ST_EOUT: begin
                    if (res_go) r_e <= r_e + PA_W'(1);
                end
                default: begin
                end
            endcase
            if (clear_msg) begin
                r_fed <= '0;
                r_ovf <= 1'b0;
            end
            if (i_cfg_wr) begin
                r_pend <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/rs_systematic_encoder_top.sv =====
// Top level of the GF(2^8) systematic Reed-Solomon parity encoder.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | i_in_valid/o_in_stall| i_symbol, i_last
//  output   | o_out_valid/i_out_stall | o_parity_symbol, o_end_of_parity, o_too_long
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_data (parity length)
//
// After reset and after every config transfer the generator is rebuilt on the one shared
// GF multiplier; no input is taken meanwhile. A message byte keeps the input stalled after
// its transfer until its remainder update is done, and the zeros of the tail are run
// through the remainder in turn. Parity bytes are read out of the remainder memory one at
// a time; an over-long message gives its error result once its last byte has been taken.
// Reset is synchronous, active low; parity length returns to 16.
// A stalled result sits in the output register while the core waits on it.
module rs_systematic_encoder_top import rse_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input items
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_last,
    // results
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [SYM_W-1:0] o_parity_symbol,
    output logic             o_end_of_parity,
    output logic             o_too_long,
    // configuration
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_plen;
    logic [PL_W-1:0]  plen_eff;
    logic             cfg_go;

    t_stat core_stat;
    t_item core_item;
    logic  core_item_valid;
    logic  core_res_valid;
    t_res  core_res;
    logic  res_ready;

    logic  r_out_valid;
    t_res  r_out_res;

    // parity length register; zero acts as one, beyond the maximum clamps
    assign o_cfg_ready = core_stat.cfg_ready;
    assign cfg_go      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= PLEN_RESET;
        end else if (cfg_go) begin
            r_plen <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_plen == '0) begin
            plen_eff = PL_W'(1);
        end else if (r_plen > CFG_W'(MAX_PARITY)) begin
            plen_eff = PL_W'(MAX_PARITY);
        end else begin
            plen_eff = PL_W'(r_plen);
        end
    end

    // input side: hold off a message byte while the core is busy or a config transfer is offered
    assign o_in_stall       = !core_stat.in_ready || i_cfg_valid;
    assign core_item_valid  = i_in_valid && !o_in_stall;
    assign core_item.symbol = i_symbol;
    assign core_item.last   = i_last;

    rse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (cfg_go),
        .i_plen_eff   (plen_eff),
        .i_item_valid (core_item_valid),
        .i_item       (core_item),
        .o_stat       (core_stat),
        .o_res_valid  (core_res_valid),
        .o_res        (core_res),
        .i_res_ready  (res_ready)
    );

    // output register: refills in the cycle the held result is transferred
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= core_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && core_res_valid) begin
            r_out_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_parity_symbol = r_out_res.parity_symbol;
    assign o_end_of_parity = r_out_res.end_of_parity;
    assign o_too_long      = r_out_res.too_long;

endmodule

// ===== rtl/rse_checker.sv =====
// Port-level assertions for the RS parity encoder, bound to the top level.
`include "assert_macros.svh"

module rse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_symbol,
    input logic       i_last,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_parity_symbol,
    input logic       o_end_of_parity,
    input logic       o_too_long,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic [6:0] i_cfg_data
);

    `RSE_ASSERT_IMP(a_err_shape, i_clk, i_rst_n, o_out_valid && o_too_long, o_end_of_parity && (o_parity_symbol == '0), "error result not final or payload not zero")

    `RSE_ASSERT_IMP(a_busy_mid_parity, i_clk, i_rst_n, o_out_valid && !o_end_of_parity, o_in_stall && !o_cfg_ready, "input or config open while parity still pending")

    `RSE_ASSERT_IMP(a_open_implies_cfg, i_clk, i_rst_n, !o_in_stall, o_cfg_ready, "input open while config closed")

    `RSE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_parity_symbol) && $stable(o_end_of_parity) && $stable(o_too_long), "stalled result changed")

endmodule

bind rs_systematic_encoder_top rse_checker u_rse_checker (.*);
